### rtl/core/rlsp_pkg.sv
// Package for the rate-limited steering plant step core.
// Holds widths, the sequencer operation codes, the multiply unit control struct
// and a small saturation helper. No dependencies.
`timescale 1ns / 1ps

package rlsp_pkg;

    localparam int unsigned W_VAL  = 24;  // Q4.20 angle / rate
    localparam int unsigned W_LIM  = 23;  // unsigned Q3.20 limit
    localparam int unsigned W_DT   = 20;  // unsigned Q0.20 step time
    localparam int unsigned W_MX   = 26;  // multiplicand operand (signed)
    localparam int unsigned W_MY   = 24;  // multiplier operand (signed, serial)
    localparam int unsigned W_ACC  = 52;  // accumulator
    localparam int unsigned W_EX   = 32;  // rounded result of an accumulation
    localparam int unsigned W_SUM  = 33;  // angle plus increment
    localparam int unsigned W_DEN  = 32;  // divider denominator
    localparam int unsigned W_FRAC = 20;  // fraction of the step, Q0.20
    localparam int unsigned W_CIDX = 3;   // config register index
    localparam int unsigned W_CDAT = 48;  // config write data

    // Config register indexes
    localparam logic [W_CIDX-1:0] CFG_A00    = 3'd0;
    localparam logic [W_CIDX-1:0] CFG_A01    = 3'd1;
    localparam logic [W_CIDX-1:0] CFG_A10    = 3'd2;
    localparam logic [W_CIDX-1:0] CFG_A11    = 3'd3;
    localparam logic [W_CIDX-1:0] CFG_GAINS  = 3'd4;
    localparam logic [W_CIDX-1:0] CFG_LIMIT  = 3'd5;
    localparam logic [W_CIDX-1:0] CFG_DT     = 3'd6;
    localparam logic [W_CIDX-1:0] CFG_BOUNDS = 3'd7;

    // Multiply-accumulate steps of one item
    typedef enum logic [3:0] {
        OP_A_ANG  = 4'd0,  // A00 * angle (clear)
        OP_A_RATE = 4'd1,  // A01 * rate
        OP_A_REQ  = 4'd2,  // B0 * request
        OP_R_ANG  = 4'd3,  // A10 * angle (clear)
        OP_R_RATE = 4'd4,  // A11 * rate
        OP_R_REQ  = 4'd5,  // B1 * request
        OP_PIN    = 4'd6,  // limited rate * dt (clear)
        OP_TACC   = 4'd7,  // fraction * dt (clear)
        OP_TRAP   = 4'd8,  // (|old| + L) * t_acc (clear)
        OP_RECT   = 4'd9   // 2L * t_const
    } t_op;

    typedef struct packed {
        logic go;     // latch operands and start
        logic clear;  // zero the accumulator first
    } t_mac_ctrl;

    function automatic logic signed [W_VAL-1:0] sat24(input logic signed [W_SUM-1:0] v);
        logic signed [W_SUM-1:0] hi;
        logic signed [W_SUM-1:0] lo;
        hi = W_SUM'(signed'({1'b0, {(W_VAL-1){1'b1}}}));
        lo = -hi - W_SUM'(1);
        if (v > hi) begin
            sat24 = W_VAL'(hi);
        end else if (v < lo) begin
            sat24 = W_VAL'(lo);
        end else begin
            sat24 = v[W_VAL-1:0];
        end
    endfunction

endpackage

### rtl/core/rlsp_if.sv
// Handshake channels of the steering plant step core: input, result, config.
// Depends on rlsp_pkg for field widths.
`timescale 1ns / 1ps

interface rlsp_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rlsp_pkg::W_VAL-1:0]      angle_request;
    modport source (output valid, output angle_request, input ready);
    modport sink   (input valid, input angle_request, output ready);
endinterface

interface rlsp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rlsp_pkg::W_VAL-1:0]      angle_out;
    logic signed [rlsp_pkg::W_VAL-1:0]      rate_out;
    logic                                   rate_limited;
    modport source (output valid, output angle_out, output rate_out,
                    output rate_limited, input ready);
    modport sink   (input valid, input angle_out, input rate_out,
                    input rate_limited, output ready);
endinterface

interface rlsp_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [rlsp_pkg::W_CIDX-1:0]            index;
    logic [rlsp_pkg::W_CDAT-1:0]            data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/rlsp_mac.sv
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle.
// Depends on rlsp_pkg.
`timescale 1ns / 1ps

module rlsp_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  rlsp_pkg::t_mac_ctrl                   i_ctrl,
    input  logic signed [rlsp_pkg::W_MX-1:0]      i_x,
    input  logic signed [rlsp_pkg::W_MY-1:0]      i_y,
    output logic signed [rlsp_pkg::W_ACC-1:0]     o_acc,
    output logic                                  o_busy,
    output logic                                  o_done
);
    import rlsp_pkg::*;

    localparam int unsigned W_CNT = $clog2(W_MY);

    logic signed [W_ACC-1:0] r_acc;
    logic signed [W_ACC-1:0] r_x;
    logic        [W_MY-1:0]  r_y;
    logic        [W_CNT-1:0] r_cnt;
    logic                    r_busy;
    logic                    r_done;
    logic                    last;

    assign last = (r_cnt == W_CNT'(W_MY - 1));

    // Control: step through the multiplier bits after a start, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + W_CNT'(1);
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift multiplicand left, multiplier right; sign bit subtracts
    always_ff @(posedge i_clk) begin
        if (i_ctrl.go) begin
            if (i_ctrl.clear) begin
                r_acc <= '0;
            end
            r_x <= W_ACC'(i_x);
            r_y <= i_y;
        end else if (r_busy) begin
            if (r_y[0]) begin
                r_acc <= last ? (r_acc - r_x) : (r_acc + r_x);
            end
            r_x <= r_x <<< 1;
            r_y <= r_y >> 1;
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

### rtl/core/rlsp_div.sv
// Restoring divider for the fraction of the step: floor(num * 2^20 / den),
// one quotient bit per cycle, num < den. Depends on rlsp_pkg.
`timescale 1ns / 1ps

module rlsp_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_go,
    input  logic [rlsp_pkg::W_LIM-1:0]        i_num,
    input  logic [rlsp_pkg::W_DEN-1:0]        i_den,
    output logic [rlsp_pkg::W_FRAC-1:0]       o_quot,
    output logic                              o_done
);
    import rlsp_pkg::*;

    localparam int unsigned W_CNT = $clog2(W_FRAC);

    logic [W_DEN:0]      r_rem;
    logic [W_DEN-1:0]    r_den;
    logic [W_FRAC-1:0]   r_q;
    logic [W_CNT-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [W_DEN+1:0]    rem2;
    logic [W_DEN+1:0]    diff;
    logic                fits;

    assign rem2 = {r_rem, 1'b0};
    assign diff = rem2 - (W_DEN+2)'(r_den);
    assign fits = !diff[W_DEN+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + W_CNT'(1);
                if (r_cnt == W_CNT'(W_FRAC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One shift-and-subtract step per cycle
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= (W_DEN+1)'(i_num);
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[W_DEN:0] : rem2[W_DEN:0];
            r_q   <= {r_q[W_FRAC-2:0], fits};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

### rtl/core/rate_limited_steering_plant_step_core.sv
// Top level of the rate-limited steering plant step core.
// Depends on rlsp_pkg, rlsp_if, rlsp_mac and rlsp_div.
`timescale 1ns / 1ps
//
// Usage:
//   i_in  : one transaction per step, carrying the requested steering angle.
//   o_out : one transaction per step: new angle, new rate, rate-limited flag.
//   i_cfg : register writes (index, data), always ready; write only while idle.
// One bit-serial multiply-accumulate unit does every product (start, a step per
// multiplier bit, done); a bit-serial divider finds the fraction of the step
// (start, a step per quotient bit, done).
// The work for an item takes one of three paths: new rate within the limit,
// old rate already at the limit, or limit reached inside the step.
// One item is in work at a time; the next input is taken the cycle after the
// result sits in the output register, even while it waits to be taken.
// A stalled receiver holds the result; the core then waits before storing the
// next one. Reset restores the register defaults and zeroes angle and rate.
module rate_limited_steering_plant_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlsp_in_if.sink     i_in,
    rlsp_out_if.source  o_out,
    rlsp_cfg_if.sink    i_cfg
);
    import rlsp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAC  = 5'b00010,
        S_DEC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // Configuration registers
    logic signed [W_VAL-1:0] r_a00, r_a01, r_a10, r_a11;
    logic        [W_CDAT-1:0] r_gains;
    logic        [W_LIM-1:0]  r_lim;
    logic        [W_DT-1:0]   r_dt;
    logic        [W_CDAT-1:0] r_bounds;

    // Model state and per-item working registers
    t_state                  r_state;
    t_op                     r_op;
    logic                    r_go;
    logic                    r_clear;
    logic                    r_dgo;
    logic signed [W_VAL-1:0] r_ang;
    logic signed [W_VAL-1:0] r_rate;
    logic signed [W_VAL-1:0] r_req;
    logic signed [W_EX-1:0]  r_ex_a;
    logic signed [W_EX-1:0]  r_ex_r;
    logic signed [W_SUM-1:0] r_sum;
    logic signed [W_VAL-1:0] r_new_r;
    logic                    r_neg;
    logic                    r_limited;
    logic        [W_FRAC-1:0] r_frac;
    logic        [W_DT-1:0]  r_tacc;
    logic                    r_out_valid;
    logic signed [W_VAL-1:0] r_out_ang;
    logic signed [W_VAL-1:0] r_out_rate;
    logic                    r_out_lim;

    // Unit signals
    t_mac_ctrl               mac_ctrl;
    logic signed [W_MX-1:0]  mac_x;
    logic signed [W_MY-1:0]  mac_y;
    logic signed [W_ACC-1:0] mac_acc;
    logic                    mac_busy;
    logic                    mac_done;
    logic        [W_FRAC-1:0] div_q;
    logic                    div_done;

    logic signed [W_ACC-1:0] acc_h20, acc_h21;
    logic signed [W_EX-1:0]  rnd20, rnd21;
    logic        [W_EX-1:0]  abs_r;
    logic        [W_VAL-1:0] mag0;
    logic        [W_DT-1:0]  tconst;
    logic signed [W_VAL-1:0] b0, b1, lo, hi;
    logic signed [W_VAL-1:0] sat_a, fin_a;
    logic                    in_fire, out_free;

    assign b0 = r_gains[W_VAL-1:0];
    assign b1 = r_gains[2*W_VAL-1:W_VAL];
    assign lo = r_bounds[W_VAL-1:0];
    assign hi = r_bounds[2*W_VAL-1:W_VAL];

    // Round half up: add half and take the upper bits (floor)
    assign acc_h20 = mac_acc + W_ACC'(1 << 19);
    assign acc_h21 = mac_acc + W_ACC'(1 << 20);
    assign rnd20   = acc_h20[W_EX+19:20];
    assign rnd21   = W_EX'(acc_h21[W_ACC-1:21]);

    assign abs_r  = r_ex_r[W_EX-1] ? W_EX'(-r_ex_r) : W_EX'(r_ex_r);
    assign mag0   = r_rate[W_VAL-1] ? W_VAL'(-r_rate) : W_VAL'(r_rate);
    assign tconst = r_dt - r_tacc;

    // Operand selection for each multiply-accumulate step
    always_comb begin
        mac_x = '0;
        mac_y = '0;
        case (r_op)
            OP_A_ANG:  begin mac_x = W_MX'(r_a00); mac_y = r_ang;  end
            OP_A_RATE: begin mac_x = W_MX'(r_a01); mac_y = r_rate; end
            OP_A_REQ:  begin mac_x = W_MX'(b0);    mac_y = r_req;  end
            OP_R_ANG:  begin mac_x = W_MX'(r_a10); mac_y = r_ang;  end
            OP_R_RATE: begin mac_x = W_MX'(r_a11); mac_y = r_rate; end
            OP_R_REQ:  begin mac_x = W_MX'(b1);    mac_y = r_req;  end
            OP_PIN: begin
                mac_x = W_MX'(r_new_r);
                mac_y = W_MY'(r_dt);
            end
            OP_TACC: begin
                mac_x = W_MX'(r_frac);
                mac_y = W_MY'(r_dt);
            end
            OP_TRAP: begin
                mac_x = W_MX'({1'b0, (W_VAL+1)'(mag0) + (W_VAL+1)'(r_lim)});
                mac_y = W_MY'(r_tacc);
            end
            OP_RECT: begin
                mac_x = W_MX'({r_lim, 1'b0});
                mac_y = W_MY'(tconst);
            end
            default: begin mac_x = '0; mac_y = '0; end
        endcase
    end

    assign mac_ctrl.go    = r_go;
    assign mac_ctrl.clear = r_clear;

    rlsp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (mac_ctrl),
        .i_x     (mac_x),
        .i_y     (mac_y),
        .o_acc   (mac_acc),
        .o_busy  (mac_busy),
        .o_done  (mac_done)
    );

    rlsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_dgo),
        .i_num   (r_lim - W_LIM'(mag0)),
        .i_den   (abs_r - W_DEN'(mag0)),
        .o_quot  (div_q),
        .o_done  (div_done)
    );

    // Handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a00    <= 24'sh100000;
            r_a01    <= '0;
            r_a10    <= '0;
            r_a11    <= 24'sh100000;
            r_gains  <= '0;
            r_lim    <= 23'h200000;
            r_dt     <= 20'd10486;
            r_bounds <= 48'd7036884064666;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_A00:    r_a00    <= i_cfg.data[W_VAL-1:0];
                CFG_A01:    r_a01    <= i_cfg.data[W_VAL-1:0];
                CFG_A10:    r_a10    <= i_cfg.data[W_VAL-1:0];
                CFG_A11:    r_a11    <= i_cfg.data[W_VAL-1:0];
                CFG_GAINS:  r_gains  <= i_cfg.data;
                CFG_LIMIT:  r_lim    <= i_cfg.data[W_LIM-1:0];
                CFG_DT:     r_dt     <= i_cfg.data[W_DT-1:0];
                CFG_BOUNDS: r_bounds <= i_cfg.data;
                default:    ;
            endcase
        end
    end

    // Final saturation and bounds clamp (min test first)
    assign sat_a = sat24(r_sum);
    always_comb begin
        if (sat_a < lo) begin
            fin_a = lo;
        end else if (sat_a > hi) begin
            fin_a = hi;
        end else begin
            fin_a = sat_a;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_A_ANG;
            r_go        <= 1'b0;
            r_clear     <= 1'b0;
            r_dgo       <= 1'b0;
            r_ang       <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_go  <= 1'b0;
            r_dgo <= 1'b0;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_req   <= i_in.angle_request;
                        r_op    <= OP_A_ANG;
                        r_go    <= 1'b1;
                        r_clear <= 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (mac_done) begin
                        r_go    <= 1'b1;
                        r_clear <= 1'b0;
                        case (r_op)
                            OP_A_ANG:  r_op <= OP_A_RATE;
                            OP_A_RATE: r_op <= OP_A_REQ;
                            OP_A_REQ: begin
                                r_ex_a  <= rnd20;
                                r_op    <= OP_R_ANG;
                                r_clear <= 1'b1;
                            end
                            OP_R_ANG:  r_op <= OP_R_RATE;
                            OP_R_RATE: r_op <= OP_R_REQ;
                            OP_R_REQ: begin
                                r_ex_r  <= rnd20;
                                r_go    <= 1'b0;
                                r_state <= S_DEC;
                            end
                            OP_PIN: begin
                                r_sum   <= W_SUM'(r_ang) + W_SUM'(rnd20);
                                r_go    <= 1'b0;
                                r_state <= S_FIN;
                            end
                            OP_TACC: begin
                                r_tacc  <= rnd20[W_DT-1:0];
                                r_op    <= OP_TRAP;
                                r_clear <= 1'b1;
                            end
                            OP_TRAP:   r_op <= OP_RECT;
                            OP_RECT: begin
                                r_sum   <= r_neg ? (W_SUM'(r_ang) - W_SUM'(rnd21))
                                                 : (W_SUM'(r_ang) + W_SUM'(rnd21));
                                r_go    <= 1'b0;
                                r_state <= S_FIN;
                            end
                            default: begin
                                r_go    <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DEC: begin
                    // Pick linear, pinned or hit-in-step
                    if (abs_r <= W_EX'(r_lim)) begin
                        r_sum     <= W_SUM'(r_ex_a);
                        r_new_r   <= sat24(W_SUM'(r_ex_r));
                        r_limited <= 1'b0;
                        r_state   <= S_FIN;
                    end else begin
                        r_limited <= 1'b1;
                        r_neg     <= r_ex_r[W_EX-1];
                        r_new_r   <= r_ex_r[W_EX-1] ? -W_VAL'(r_lim) : W_VAL'(r_lim);
                        if (mag0 >= W_VAL'(r_lim)) begin
                            r_op    <= OP_PIN;
                            r_go    <= 1'b1;
                            r_clear <= 1'b1;
                            r_state <= S_MAC;
                        end else begin
                            r_dgo   <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_frac  <= div_q;
                        r_op    <= OP_TACC;
                        r_go    <= 1'b1;
                        r_clear <= 1'b1;
                        r_state <= S_MAC;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_ang   <= fin_a;
                        r_out_rate  <= r_new_r;
                        r_out_lim   <= r_limited;
                        r_ang       <= fin_a;
                        r_rate      <= r_new_r;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.angle_out    = r_out_ang;
    assign o_out.rate_out     = r_out_rate;
    assign o_out.rate_limited = r_out_lim;

    // The multiplier and divider never start together
    a_single_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_go && r_dgo))
        else $error("multiplier and divider started in the same cycle");

    // No new input while the multiplier is running
    a_idle_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !mac_busy)
        else $error("input ready while multiplier busy");

    // A limited result carries exactly the limit magnitude
    a_lim_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_lim) |->
            (r_out_rate == W_VAL'(r_lim) || r_out_rate == -W_VAL'(r_lim)))
        else $error("limited rate differs from the limit");

    // A result is stored only when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_valid && !o_out.ready) |=> (r_state == S_FIN))
        else $error("result stored over a pending one");

endmodule
